// ===== rtl/snm_pkg.sv =====
// Shared types, constants and helper functions for the scale note grid mapper.
// Depends on nothing; the map store, sequencer and top level import it.
`default_nettype none

package snm_pkg;

    // Grid geometry.
    localparam int MAX_COLUMNS = 8;
    localparam int MAX_ROWS    = 8;
    localparam int MAP_DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(MAP_DEPTH);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // Note values.
    localparam logic [7:0] EMPTY_NOTE = 8'd255;
    localparam logic [7:0] TOP_NOTE   = 8'd127;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_KEY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OVERLAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ROOT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENFORCE_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLUMNS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS    = 3'd7;

    // Command opcodes.
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;

    // Pitch classification codes.
    localparam logic [1:0] KIND_OUT   = 2'd0;
    localparam logic [1:0] KIND_SCALE = 2'd1;
    localparam logic [1:0] KIND_ROOT  = 2'd2;

    // Number of scale search steps before a cell is given up as empty.
    localparam logic [3:0] SEARCH_LIMIT = 4'd13;

    typedef struct packed {
        logic [3:0]  root_key;
        logic [3:0]  octave;
        logic [11:0] scale_mask;
        logic [2:0]  row_overlap;
        logic        align_root;
        logic        enforce_scale;
        logic [3:0]  active_columns;
        logic [3:0]  active_rows;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_map_req;

    // Root key reduced to a pitch class; inputs are at most fifteen.
    function automatic logic [3:0] root_class(input logic [3:0] rk);
        return (rk >= 4'd12) ? rk - 4'd12 : rk;
    endfunction

    // Scale mask rotated left by the root pitch class (0 to 11).
    function automatic logic [11:0] rotate_mask(input logic [11:0] m, input logic [3:0] rk);
        logic [23:0] dbl;
        dbl = {m, m} << rk;
        return dbl[23:12];
    endfunction

    // Pitch class of a note of 0 to 127: the quotient by twelve comes from
    // multiplying by 43/512, which is exact over this range.
    function automatic logic [3:0] pitch_class(input logic [6:0] note);
        logic [12:0] prod;
        logic [3:0]  quo;
        logic [7:0]  twelve_q;
        prod     = {6'd0, note} * 13'd43;
        quo      = prod[12:9];
        twelve_q = {1'b0, quo, 3'd0} + {2'b0, quo, 2'd0};
        return 4'(({1'b0, note} - twelve_q));
    endfunction

    // Classification of a note against the rotated scale.
    function automatic logic [1:0] pitch_kind(input logic [6:0]  note,
                                              input logic [3:0]  rk,
                                              input logic [11:0] aligned);
        logic [3:0] pc;
        pc = pitch_class(note);
        if (pc == rk) begin
            return KIND_ROOT;
        end
        return aligned[pc] ? KIND_SCALE : KIND_OUT;
    endfunction

    // Size register saturated into 1 .. max.
    function automatic logic [4:0] clamp_size(input logic [3:0] v, input logic [4:0] max);
        if (v == 4'd0) begin
            return 5'd1;
        end
        return ({1'b0, v} > max) ? max : {1'b0, v};
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'd255) ? 8'd255 : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/snm_stream_if.sv =====
// Valid/ready stream interfaces for the command and cell result channels.
// Standalone; widths follow the fixed field widths of the block.
`default_nettype none

interface snm_cmd_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [2:0] row;
    logic [2:0] column;

    modport source (output valid, output opcode, output row, output column, input ready);
    modport sink   (input valid, input opcode, input row, input column, output ready);
endinterface

interface snm_cell_if;
    logic       valid;
    logic       ready;
    logic [2:0] cell_row;
    logic [2:0] cell_column;
    logic [7:0] note;
    logic       last;

    modport source (output valid, output cell_row, output cell_column, output note,
                    output last, input ready);
    modport sink   (input valid, input cell_row, input cell_column, input note,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/snm_map_ram.sv =====
// Note map store: synchronous single-port memory with registered read data and
// per-entry valid flags so that unwritten entries read as empty. Uses snm_pkg.
`default_nettype none

module snm_map_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  snm_pkg::t_map_req   i_req,
    output logic [7:0]          o_rdata
);
    import snm_pkg::*;

    logic [7:0]           mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_valid;
    logic [7:0]           r_rdata;
    logic                 r_rd_valid;

    // Memory array: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    // Valid flags are cleared at reset, which empties the whole map at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : EMPTY_NOTE;

    // The controller never reads and writes in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.wr_en && i_req.rd_en))
        else $error("map store read and written in the same cycle");

    // A written entry reads back as valid at the next read of it.
    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |=> r_valid[$past(i_req.addr)])
        else $error("written entry not marked valid");

    // Stored notes are always MIDI notes or the empty code.
    a_stored_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |-> (i_req.wdata <= TOP_NOTE || i_req.wdata == EMPTY_NOTE))
        else $error("out of range note written to map store");

endmodule

`default_nettype wire

// ===== rtl/snm_ctrl.sv =====
// Sequencer for generate and lookup commands: walks the grid, runs the scale
// search one note per cycle, stalled at a found note by a full result register,
// and holds that register. Uses snm_pkg and the stream interfaces; drives the map store.
`default_nettype none

module snm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  snm_pkg::t_cfg      i_cfg,
    snm_cmd_if.sink            i_cmd,
    snm_cell_if.source         o_cell,
    output snm_pkg::t_map_req  o_req,
    input  logic [7:0]         i_rdata
);
    import snm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_CELL = 3'd3;
    localparam logic [2:0] S_LOOK = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_y, n_y;
    logic [COL_W-1:0] r_x, n_x;
    logic [7:0]       r_next, n_next;
    logic [7:0]       r_root, n_root;
    logic [7:0]       r_seen, n_seen;
    logic [3:0]       r_tries, n_tries;

    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_row, n_out_row;
    logic [2:0]       r_out_col, n_out_col;
    logic [7:0]       r_out_note, n_out_note;
    logic             r_out_last, n_out_last;

    logic [4:0]       cols, rows;
    logic [ROW_W-1:0] rows_m1, cur_r;
    logic [COL_W-1:0] cols_m1;
    logic [3:0]       rk;
    logic [11:0]      aligned;
    logic             overlap_on;
    logic             out_free;
    logic [1:0]       kind;
    logic             hit;
    logic             give_up;
    logic             row_end, grid_end;
    logic [7:0]       first_note;
    logic             accept;

    // Settings derived from the configuration registers.
    always_comb begin
        cols       = clamp_size(i_cfg.active_columns, 5'(MAX_COLUMNS));
        rows       = clamp_size(i_cfg.active_rows, 5'(MAX_ROWS));
        cols_m1    = COL_W'(cols - 5'd1);
        rows_m1    = ROW_W'(rows - 5'd1);
        rk         = root_class(i_cfg.root_key);
        aligned    = rotate_mask(i_cfg.scale_mask, rk);
        overlap_on = (i_cfg.row_overlap != 3'd0) && ({2'b0, i_cfg.row_overlap} < cols);
        first_note = {1'b0, i_cfg.octave, 3'd0} + {2'b0, i_cfg.octave, 2'd0}
                   + {4'd0, i_cfg.root_key};
    end

    // Cell walk and scale search step.
    always_comb begin
        cur_r    = rows_m1 - r_y;
        kind     = pitch_kind(r_next[6:0], rk, aligned);
        hit      = !i_cfg.enforce_scale || (kind != KIND_OUT);
        give_up  = r_next[7] || (r_tries == SEARCH_LIMIT);
        row_end  = (r_x == cols_m1);
        grid_end = row_end && (r_y == rows_m1);
        out_free = !r_out_valid || o_cell.ready;
        accept   = i_cmd.valid && i_cmd.ready;
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_y         = r_y;
        n_x         = r_x;
        n_next      = r_next;
        n_root      = r_root;
        n_seen      = r_seen;
        n_tries     = r_tries;
        n_out_valid = r_out_valid && !o_cell.ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_note  = r_out_note;
        n_out_last  = r_out_last;
        o_req       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == OP_LOOKUP) begin
                        n_y        = i_cmd.row;
                        n_x        = i_cmd.column;
                        o_req.rd_en = 1'b1;
                        o_req.addr  = {i_cmd.row, i_cmd.column};
                        n_state    = S_LOOK;
                    end else begin
                        n_root  = first_note;
                        n_next  = first_note;
                        n_seen  = 8'd0;
                        n_y     = '0;
                        n_x     = '0;
                        n_tries = '0;
                        n_state = S_ROW;
                    end
                end
            end

            S_ROW: begin
                // Row start: overlap from the row below, or octave realignment.
                n_tries = '0;
                if (overlap_on) begin
                    if (r_y != '0) begin
                        o_req.rd_en = 1'b1;
                        o_req.addr  = {cur_r + ROW_W'(1), i_cfg.row_overlap};
                        n_state     = S_LOAD;
                    end else begin
                        n_state = S_CELL;
                    end
                end else begin
                    if (i_cfg.align_root && (r_seen >= 8'd2)) begin
                        n_root = (r_root <= 8'd243) ? r_root + 8'd12 : 8'd255;
                        n_next = (r_root <= 8'd243) ? r_root + 8'd12 : 8'd255;
                        n_seen = 8'd0;
                    end
                    n_state = S_CELL;
                end
            end

            S_LOAD: begin
                n_next  = i_rdata;
                n_state = S_CELL;
            end

            S_CELL: begin
                if (give_up || hit) begin
                    // Emission of one cell, held while the result register is full.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_row   = cur_r;
                        n_out_col   = r_x;
                        n_out_note  = give_up ? EMPTY_NOTE : r_next;
                        n_out_last  = grid_end;
                        o_req.wr_en = 1'b1;
                        o_req.addr  = {cur_r, r_x};
                        o_req.wdata = give_up ? EMPTY_NOTE : r_next;
                        n_tries     = '0;
                        if (!give_up) begin
                            n_next = sat_inc(r_next);
                            if (kind == KIND_ROOT) begin
                                n_seen = sat_inc(r_seen);
                            end
                        end
                        if (grid_end) begin
                            n_state = S_IDLE;
                        end else if (row_end) begin
                            n_x     = '0;
                            n_y     = r_y + ROW_W'(1);
                            n_state = S_ROW;
                        end else begin
                            n_x = r_x + COL_W'(1);
                        end
                    end
                end else begin
                    // Note outside the scale: skip it.
                    n_next  = sat_inc(r_next);
                    n_tries = r_tries + 4'd1;
                end
            end

            S_LOOK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_y;
                    n_out_col   = r_x;
                    n_out_note  = (({2'b0, r_y} < rows) && ({2'b0, r_x} < cols))
                                ? i_rdata : EMPTY_NOTE;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next      <= 8'd0;
            r_root      <= 8'd0;
            r_seen      <= 8'd0;
            r_tries     <= 4'd0;
            r_y         <= '0;
            r_x         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_next      <= n_next;
            r_root      <= n_root;
            r_seen      <= n_seen;
            r_tries     <= n_tries;
            r_y         <= n_y;
            r_x         <= n_x;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_note <= n_out_note;
        r_out_last <= n_out_last;
    end

    assign o_cell.valid       = r_out_valid;
    assign o_cell.cell_row    = r_out_row;
    assign o_cell.cell_column = r_out_col;
    assign o_cell.note        = r_out_note;
    assign o_cell.last        = r_out_last;

    // A lookup transaction always moves to the read state next.
    a_lookup_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.opcode == OP_LOOKUP) |=> (r_state == S_LOOK))
        else $error("lookup did not enter read state");

    // Every map write in a generation goes with a reported cell.
    a_write_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.wr_en |=> (r_out_valid && r_out_row == $past(cur_r) && r_out_col == $past(r_x)))
        else $error("map write without matching cell report");

    // After the final cell of a command the sequencer is idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && n_out_last && out_free && r_state != S_IDLE) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final cell");

    // The scale search never runs past its step limit.
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= SEARCH_LIMIT)
        else $error("scale search ran past its limit");

endmodule

`default_nettype wire

// ===== rtl/scale_note_grid_mapper_unit.sv =====
// Top level of the scale note grid mapper: configuration registers, sequencer
// and note map store. Uses snm_pkg, snm_stream_if, snm_map_ram and snm_ctrl.
//
//   Channel   Dir  Handshake          Payload
//   i_cmd     in   valid/ready        opcode, row, column
//   o_cell    out  valid/ready        cell_row, cell_column, note, last
//   i_cfg_*   in   write enable only  index 0..7, data 12 bits
//
// A lookup reads the map store, then loads the result register. A generate
// command is accepted, then passes a row start state for each row (followed by
// a load state for rows above the bottom one with row overlap, for the store
// read of the row below) and stays in the cell state for each cell and for each
// note skipped by the scale search.
// Reset clears all map entries to empty at once through the valid flags.
// A full result register stalls the search at the cell emission step.
`default_nettype none

module scale_note_grid_mapper_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    snm_cmd_if.sink                          i_cmd,
    snm_cell_if.source                       o_cell,
    input  logic                             i_cfg_we,
    input  logic [snm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [snm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import snm_pkg::*;

    t_cfg       r_cfg;
    t_map_req   map_req;
    logic [7:0] map_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.root_key       <= 4'd0;
            r_cfg.octave         <= 4'd3;
            r_cfg.scale_mask     <= 12'd2741;
            r_cfg.row_overlap    <= 3'd0;
            r_cfg.align_root     <= 1'b1;
            r_cfg.enforce_scale  <= 1'b0;
            r_cfg.active_columns <= 4'd8;
            r_cfg.active_rows    <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROOT_KEY:       r_cfg.root_key       <= i_cfg_data[3:0];
                REG_OCTAVE:         r_cfg.octave         <= i_cfg_data[3:0];
                REG_SCALE_MASK:     r_cfg.scale_mask     <= i_cfg_data[11:0];
                REG_ROW_OVERLAP:    r_cfg.row_overlap    <= i_cfg_data[2:0];
                REG_ALIGN_ROOT:     r_cfg.align_root     <= i_cfg_data[0];
                REG_ENFORCE_SCALE:  r_cfg.enforce_scale  <= i_cfg_data[0];
                REG_ACTIVE_COLUMNS: r_cfg.active_columns <= i_cfg_data[3:0];
                REG_ACTIVE_ROWS:    r_cfg.active_rows    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Command sequencer.
    snm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (i_cmd),
        .o_cell  (o_cell),
        .o_req   (map_req),
        .i_rdata (map_rdata)
    );

    // Note map store.
    snm_map_ram u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rdata (map_rdata)
    );

endmodule

`default_nettype wire
